/* design/ep0sr_pkg.sv */
// Package for the endpoint-0 standard request responder.
// Holds beat types, request codes, the descriptor ROM contents and the FSM type.
// No dependencies; every other design file except ep0sr_ram imports it.
package ep0sr_pkg;

    // Descriptor ROM geometry.
    localparam int DESC_ROM_BYTES = 128;
    localparam int DESC_USED      = 102;
    localparam int ROM_AW         = $clog2(DESC_ROM_BYTES);
    localparam int USED_AW        = $clog2(DESC_USED);

    // String descriptors held in the ROM, and how many the device reports.
    localparam int ROM_STRINGS  = 5;
    localparam int STRING_COUNT = 5;
    localparam int STR_IW       = $clog2(ROM_STRINGS);

    // Longest reply, in bytes.
    localparam int MAX_LEN = 32;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // Event selectors.
    typedef enum logic [1:0] {
        EVT_BUS_RESET = 2'd0,
        EVT_TX_DONE   = 2'd1,
        EVT_RX_TOKEN  = 2'd2,
        EVT_OTHER_EP  = 2'd3
    } evt_kind_t;

    // Response kinds.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_STALL = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [3:0]  PID_SETUP      = 4'd13;
    localparam logic [15:0] REQ_GET_DESC   = 16'h0680;
    localparam logic [15:0] REQ_SET_ADDR   = 16'h0500;
    localparam logic [15:0] REQ_SET_CONFIG = 16'h0900;
    localparam logic [15:0] REQ_SET_IFACE  = 16'h0b01;

    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;

    localparam logic [ROM_AW-1:0] OFS_DEVICE = ROM_AW'(0);
    localparam logic [LEN_W-1:0]  LEN_DEVICE = LEN_W'(18);
    localparam logic [ROM_AW-1:0] OFS_CONFIG = ROM_AW'(18);
    localparam logic [LEN_W-1:0]  LEN_CONFIG = LEN_W'(32);

    localparam logic [ROM_AW-1:0] STR_OFS [ROM_STRINGS] = '{
        ROM_AW'(50), ROM_AW'(54), ROM_AW'(66), ROM_AW'(78), ROM_AW'(88)
    };
    localparam logic [LEN_W-1:0] STR_LEN [ROM_STRINGS] = '{
        LEN_W'(4), LEN_W'(12), LEN_W'(12), LEN_W'(10), LEN_W'(14)
    };

    // Descriptor bytes; everything past the used part reads as zero.
    localparam logic [7:0] DESC_TABLE [DESC_USED] = '{
        // device descriptor
        8'd18, 8'd1, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd64, 8'h55, 8'hf0,
        8'h36, 8'h4b, 8'h34, 8'h12, 8'd1, 8'd2, 8'd3, 8'd1,
        // configuration, interface and two bulk endpoints
        8'd9, 8'd2, 8'd32, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd250,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'h53, 8'h53, 8'd4,
        8'd7, 8'd5, 8'h03, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h83, 8'd2, 8'd64, 8'd0, 8'd0,
        // string zero: language id
        8'd4, 8'd3, 8'h09, 8'h04,
        // string one
        8'd12, 8'd3, 8'h52, 8'h00, 8'h61, 8'h00, 8'h6c, 8'h00, 8'h70, 8'h00,
        8'h68, 8'h00,
        // string two
        8'd12, 8'd3, 8'h42, 8'h00, 8'h6c, 8'h00, 8'h69, 8'h00, 8'h6e, 8'h00,
        8'h6b, 8'h00,
        // string three
        8'd10, 8'd3, 8'h31, 8'h00, 8'h33, 8'h00, 8'h33, 8'h00, 8'h37, 8'h00,
        // string four
        8'd14, 8'd3, 8'h4a, 8'h00, 8'h75, 8'h00, 8'h6d, 8'h00, 8'h70, 8'h00,
        8'h65, 8'h00, 8'h72, 8'h00
    };

    // One input beat.
    typedef struct packed {
        evt_kind_t   req_type;
        logic [3:0]  token_pid;
        logic        bank_odd;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } in_beat_t;

    // One output beat.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       last;
        logic       tx_bank;
        logic [7:0] device_address;
    } out_beat_t;

    // Endpoint state word kept in the state RAM.
    typedef struct packed {
        logic [7:0] cur_addr;
        logic [7:0] pend_addr;
        logic       addr_pend;
        logic       bank;
    } ep_state_t;

    localparam int STATE_W     = $bits(ep_state_t);
    localparam int STATE_DEPTH = 2;
    localparam int STATE_AW    = $clog2(STATE_DEPTH);
    localparam logic [STATE_AW-1:0] STATE_ENTRY = '0;

    // Result of decoding one event against the current state.
    typedef struct packed {
        kind_t             kind;
        logic [ROM_AW-1:0] ofs;
        logic [LEN_W-1:0]  len;
        ep_state_t         state;
    } dec_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOAD = 2'd1,
        ST_EMIT = 2'd2
    } fsm_t;

    // Descriptor ROM lookup. The used part never exceeds the ROM size.
    function automatic logic [7:0] desc_byte(input logic [ROM_AW:0] idx);
        logic [7:0] b;
        b = 8'd0;
        if (idx < (ROM_AW + 1)'(DESC_USED))
        begin
            b = DESC_TABLE[idx[USED_AW-1:0]];
        end
        return b;
    endfunction

endpackage

/* design/ep0sr_evt_if.sv */
// Event channel interface: valid/ready handshake carrying one input beat.
// Depends on ep0sr_pkg.
interface ep0sr_evt_if
    import ep0sr_pkg::*;
();
    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/ep0sr_rsp_if.sv */
// Response channel interface: valid/ready handshake carrying one output beat.
// Depends on ep0sr_pkg.
interface ep0sr_rsp_if
    import ep0sr_pkg::*;
();
    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/ep0sr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ep0sr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* design/ep0sr_decode.sv */
// Event decoder: applies one event to the endpoint state and picks the reply.
// Depends on ep0sr_pkg.
module ep0sr_decode
    import ep0sr_pkg::*;
(
    input  in_beat_t  item,
    input  ep_state_t cur,
    output dec_t      res
);
    logic [15:0]       setup_req;
    logic [7:0]        dtype;
    logic [7:0]        dindex;
    logic [ROM_AW-1:0] full_ofs;
    logic [LEN_W-1:0]  full_len;
    logic [LEN_W-1:0]  capped;
    logic              has_data;
    logic              ok;

    assign setup_req = {item.request_code, item.request_type};
    assign dtype     = item.request_value[15:8];
    assign dindex    = item.request_value[7:0];

    always_comb
    begin
        res       = '{kind: KIND_NONE, ofs: '0, len: LEN_W'(1), state: cur};
        full_ofs  = '0;
        full_len  = '0;
        has_data  = 1'b0;
        ok        = 1'b0;
        capped    = '0;
        unique case (item.req_type)
            EVT_BUS_RESET:
            begin
                // The pending address survives a bus reset.
                res.state.cur_addr = '0;
                res.state.bank     = 1'b0;
            end
            EVT_TX_DONE:
            begin
                res.state.bank = ~item.bank_odd;
                if (cur.addr_pend)
                begin
                    res.state.cur_addr = cur.pend_addr;
                end
                res.state.addr_pend = 1'b0;
            end
            EVT_OTHER_EP:
            begin
                res.kind = KIND_NONE;
            end
            EVT_RX_TOKEN:
            begin
                if (item.token_pid != PID_SETUP)
                begin
                    res.kind = KIND_STALL;
                end
                else
                begin
                    if (setup_req == REQ_GET_DESC)
                    begin
                        if (dtype == DT_DEVICE)
                        begin
                            full_ofs = OFS_DEVICE;
                            full_len = LEN_DEVICE;
                            has_data = 1'b1;
                        end
                        else if (dtype == DT_CONFIG)
                        begin
                            full_ofs = OFS_CONFIG;
                            full_len = LEN_CONFIG;
                            has_data = 1'b1;
                        end
                        else if (dtype == DT_STRING && dindex < 8'(STRING_COUNT)
                                 && dindex < 8'(ROM_STRINGS))
                        begin
                            full_ofs = STR_OFS[dindex[STR_IW-1:0]];
                            full_len = STR_LEN[dindex[STR_IW-1:0]];
                            has_data = 1'b1;
                        end
                        ok = has_data;
                    end
                    else if (setup_req == REQ_SET_ADDR)
                    begin
                        // The new address takes effect after the status stage.
                        res.state.pend_addr = dindex;
                        res.state.addr_pend = 1'b1;
                        ok = 1'b1;
                    end
                    else if (setup_req == REQ_SET_CONFIG || setup_req == REQ_SET_IFACE)
                    begin
                        ok = 1'b1;
                    end

                    if (item.request_length < 16'(full_len))
                    begin
                        capped = item.request_length[LEN_W-1:0];
                    end
                    else
                    begin
                        capped = full_len;
                    end

                    if (!ok)
                    begin
                        res.kind = KIND_STALL;
                    end
                    else if (has_data && capped != '0)
                    begin
                        res.kind = KIND_DATA;
                        res.ofs  = full_ofs;
                        res.len  = capped;
                    end
                    else
                    begin
                        res.kind = KIND_ACK;
                    end
                end
            end
        endcase
    end
endmodule

/* design/ep0sr_ctrl.sv */
// Sequencer: accepts events, reads and writes back the state RAM, and
// streams reply beats through an output register. Depends on ep0sr_pkg
// and the two channel interfaces.
module ep0sr_ctrl
    import ep0sr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ep0sr_evt_if.sink           evt,
    ep0sr_rsp_if.source         rsp,
    output logic                ram_rd_en,
    output logic                ram_wr_en,
    output ep_state_t           ram_wr_data,
    input  ep_state_t           ram_rd_data,
    output in_beat_t            dec_item,
    output ep_state_t           dec_cur,
    input  dec_t                dec_res
);
    fsm_t              state_reg, state_next;
    in_beat_t          item_reg;
    logic              st_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [ROM_AW-1:0] ofs_reg, ofs_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              bank_reg, bank_next;
    logic [7:0]        addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_data_reg, out_data_next;
    logic              accept;
    logic              slot_free;
    logic              is_last;
    logic [7:0]        rom_byte;

    assign evt.ready = (state_reg == ST_IDLE);
    assign accept    = evt.valid && evt.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign ram_rd_en   = accept;
    assign ram_wr_en   = (state_reg == ST_LOAD);
    assign ram_wr_data = dec_res.state;

    // The state entry has never been written right after reset.
    assign dec_cur  = st_valid_reg ? ram_rd_data : '0;
    assign dec_item = item_reg;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign is_last   = (cnt_reg == len_reg - LEN_W'(1));
    assign rom_byte  = desc_byte({1'b0, ofs_reg} + (ROM_AW + 1)'(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (ram_wr_en)
            begin
                st_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= evt.data;
        end
        kind_reg     <= kind_next;
        ofs_reg      <= ofs_next;
        len_reg      <= len_next;
        cnt_reg      <= cnt_next;
        bank_reg     <= bank_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        ofs_next       = ofs_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        bank_next      = bank_reg;
        addr_next      = addr_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                kind_next  = dec_res.kind;
                ofs_next   = dec_res.ofs;
                len_next   = dec_res.len;
                cnt_next   = '0;
                bank_next  = dec_res.state.bank;
                addr_next  = dec_res.state.cur_addr;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.kind           = kind_reg;
                    out_data_next.data_byte      = (kind_reg == KIND_DATA) ? rom_byte : 8'd0;
                    out_data_next.last           = is_last;
                    out_data_next.tx_bank        = bank_reg;
                    out_data_next.device_address = addr_reg;
                    cnt_next                     = cnt_reg + LEN_W'(1);
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted event is followed directly by the read-modify-write load state.
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOAD)
        else $error("accepted event did not enter the load cycle");

    a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> state_reg == ST_EMIT)
        else $error("load cycle not followed by emission");

    // Read and write of the state entry never coincide.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_rd_en && ram_wr_en))
        else $error("state RAM read and write in the same cycle");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && is_last) |=>
        (state_reg == ST_IDLE && out_valid_reg && out_data_reg.last))
        else $error("final beat did not close the reply");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.kind != KIND_DATA) |-> out_data_reg.last)
        else $error("non-data beat without last");
endmodule

/* design/usb_ep0_standard_request_responder.sv */
// Top level of the USB endpoint-0 standard request responder.
// Depends on ep0sr_pkg, ep0sr_evt_if, ep0sr_rsp_if, ep0sr_ram, ep0sr_decode
// and ep0sr_ctrl.
//
//   Port   Role    Beat contents
//   evt    sink    one endpoint-0 event: selector, token PID, bank, setup fields
//   rsp    source  one reply beat: kind, descriptor byte, last, bank, address
//
// After acceptance of an event the sequencer reads the state word from the
// state RAM, decodes the event and writes the word back in the load state,
// then sends N reply beats (1, or up to 32 descriptor bytes) one beat per
// cycle while rsp is not stalled, and only then is ready again.
// Reset clears the sequencer, the output valid flag and the valid flag of the
// state entry; until the first write-back the state reads as all zero.
// A stalled rsp holds the reply sequencer; a new event is accepted while the
// final reply beat still waits in the output register.
module usb_ep0_standard_request_responder
    import ep0sr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ep0sr_evt_if.sink   evt,
    ep0sr_rsp_if.source rsp
);
    logic      ram_rd_en;
    logic      ram_wr_en;
    ep_state_t ram_wr_data;
    ep_state_t ram_rd_data;
    in_beat_t  dec_item;
    ep_state_t dec_cur;
    dec_t      dec_res;

    // The whole endpoint state (addresses, pending flag, transmit bank) is
    // one word in this RAM; the sequencer reads it on acceptance and writes
    // the updated word back in the following cycle.
    ep0sr_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (STATE_ENTRY),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (STATE_ENTRY),
        .rd_data (ram_rd_data)
    );

    // Decodes the held event against the state word read from the RAM.
    ep0sr_decode u_decode (
        .item (dec_item),
        .cur  (dec_cur),
        .res  (dec_res)
    );

    // Handshakes, read-modify-write sequencing and reply streaming.
    ep0sr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .rsp         (rsp),
        .ram_rd_en   (ram_rd_en),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_data (ram_wr_data),
        .ram_rd_data (ram_rd_data),
        .dec_item    (dec_item),
        .dec_cur     (dec_cur),
        .dec_res     (dec_res)
    );
endmodule
